### rtl/smsub_pkg.sv
// Shared types and constants of the sphere mesh subdivider.
`default_nettype none
package smsub_pkg;

  localparam int unsigned CornerW   = 8;
  localparam int unsigned KeyW      = 2 * CornerW;
  localparam int unsigned EdgeDepth = 1 << KeyW;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned DirW      = 16;
  localparam int unsigned PosW      = 17;
  localparam int unsigned SumW      = DirW + 1;
  localparam int unsigned RadW      = 16;
  localparam int unsigned StoreW    = 3 * DirW;
  localparam int unsigned EntryW    = IdxW + 1;
  localparam logic [RadW-1:0] RadiusReset = 16'd256;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_FACET = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_FACET  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_CHECK, ST_PICK,
    ST_SRCP, ST_SRCQ, ST_SUM, ST_NORM, ST_EMITV, ST_EMITF, ST_ERR
  } ctl_state_e;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SQ, NS_ROOT, NS_DSET, NS_DIV, NS_SCALE
  } norm_state_e;

  typedef struct packed {
    logic                   start;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] sz;
  } norm_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [DirW-1:0] dx;
    logic signed [DirW-1:0] dy;
    logic signed [DirW-1:0] dz;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
  } norm_rsp_t;

  function automatic logic [KeyW-1:0] edge_key(input logic [CornerW-1:0] p,
                                               input logic [CornerW-1:0] q);
    edge_key = (p < q) ? {p, q} : {q, p};
  endfunction

endpackage
`default_nettype wire

### rtl/smsub_norm.sv
// Bit-serial normalizer: midpoint length, reciprocal scaling and radius product.
`default_nettype none
module smsub_norm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [smsub_pkg::RadW-1:0]          radius_i,
  input  smsub_pkg::norm_req_t                req_i,
  output smsub_pkg::norm_rsp_t                rsp_o
);
  import smsub_pkg::*;

  norm_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] ci_q, ci_d;
  logic done_q, done_d;

  logic signed [SumW-1:0] sx_q, sy_q, sz_q, sx_d, sy_d, sz_d;
  logic [33:0] acc_q, acc_d;
  logic [63:0] x_q, x_d;
  logic [33:0] rr_q, rr_d;
  logic [31:0] root_q, root_d;
  logic [31:0] drem_q, drem_d;
  logic [16:0] dnum_q, dnum_d;
  logic [16:0] dq_q, dq_d;
  logic signed [DirW-1:0] dir_q [3];
  logic signed [DirW-1:0] dir_d [3];
  logic signed [PosW-1:0] pos_q [3];
  logic signed [PosW-1:0] pos_d [3];

  logic signed [SumW-1:0] cur_s;
  logic [16:0] s_abs;
  logic [33:0] sq;
  logic [33:0] acc_sum;
  logic [35:0] r_sh, trial;
  logic        r_ge;
  logic [46:0] num;
  logic [32:0] t_div, len_ext;
  logic        d_ge;
  logic [15:0] dmag;
  logic [31:0] pprod;
  logic [16:0] pmag;

  always_comb begin
    case (ci_q)
      2'd0:    cur_s = sx_q;
      2'd1:    cur_s = sy_q;
      default: cur_s = sz_q;
    endcase
    s_abs   = cur_s[SumW-1] ? 17'(-cur_s) : 17'(cur_s);
    sq      = s_abs * s_abs;
    acc_sum = acc_q + sq;
    r_sh    = {rr_q, x_q[63:62]};
    trial   = {2'b00, root_q, 2'b01};
    r_ge    = r_sh >= trial;
    num     = 47'({s_abs, 29'd0}) + 47'(root_q[31:1]);
    t_div   = {drem_q, dnum_q[16]};
    len_ext = {1'b0, root_q};
    d_ge    = t_div >= len_ext;
    if (root_q == 32'd0) begin
      dmag = 16'd0;
    end else if (cur_s[SumW-1]) begin
      dmag = (dq_q > 17'd32768) ? 16'd32768 : dq_q[15:0];
    end else begin
      dmag = (dq_q > 17'd32767) ? 16'd32767 : dq_q[15:0];
    end
    pprod = dmag * radius_i;
    pmag  = 17'((33'(pprod) + 33'd16384) >> 15);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      NS_IDLE:  if (req_i.start) state_d = NS_SQ;
      NS_SQ:    if (ci_q == 2'd2) state_d = NS_ROOT;
      NS_ROOT:  if (cnt_q == 5'd0) state_d = NS_DSET;
      NS_DSET:  state_d = NS_DIV;
      NS_DIV:   if (cnt_q == 5'd0) state_d = NS_SCALE;
      NS_SCALE: state_d = (ci_q == 2'd2) ? NS_IDLE : NS_DSET;
      default:  state_d = NS_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    ci_d   = ci_q;
    done_d = 1'b0;
    sx_d   = sx_q;
    sy_d   = sy_q;
    sz_d   = sz_q;
    acc_d  = acc_q;
    x_d    = x_q;
    rr_d   = rr_q;
    root_d = root_q;
    drem_d = drem_q;
    dnum_d = dnum_q;
    dq_d   = dq_q;
    dir_d  = dir_q;
    pos_d  = pos_q;
    case (state_q)
      NS_IDLE: begin
        if (req_i.start) begin
          sx_d  = req_i.sx;
          sy_d  = req_i.sy;
          sz_d  = req_i.sz;
          acc_d = 34'd0;
          ci_d  = 2'd0;
        end
      end
      NS_SQ: begin
        acc_d = acc_sum;
        ci_d  = ci_q + 2'd1;
        if (ci_q == 2'd2) begin
          x_d    = {2'b00, acc_sum, 28'd0};
          rr_d   = 34'd0;
          root_d = 32'd0;
          cnt_d  = 5'd31;
          ci_d   = 2'd0;
        end
      end
      NS_ROOT: begin
        rr_d   = r_ge ? 34'(r_sh - trial) : 34'(r_sh);
        root_d = {root_q[30:0], r_ge};
        x_d    = {x_q[61:0], 2'b00};
        cnt_d  = cnt_q - 5'd1;
      end
      NS_DSET: begin
        drem_d = 32'(num[46:17]);
        dnum_d = num[16:0];
        dq_d   = 17'd0;
        cnt_d  = 5'd16;
      end
      NS_DIV: begin
        drem_d = d_ge ? 32'(t_div - len_ext) : 32'(t_div);
        dnum_d = {dnum_q[15:0], 1'b0};
        dq_d   = {dq_q[15:0], d_ge};
        cnt_d  = cnt_q - 5'd1;
      end
      NS_SCALE: begin
        dir_d[ci_q] = cur_s[SumW-1] ? 16'(-dmag) : dmag;
        pos_d[ci_q] = cur_s[SumW-1] ? 17'(-pmag) : pmag;
        ci_d        = ci_q + 2'd1;
        done_d      = (ci_q == 2'd2);
      end
      default: begin
        cnt_d = 5'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      cnt_q   <= 5'd0;
      ci_q    <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ci_q    <= ci_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sz_q   <= sz_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    rr_q   <= rr_d;
    root_q <= root_d;
    drem_q <= drem_d;
    dnum_q <= dnum_d;
    dq_q   <= dq_d;
    dir_q  <= dir_d;
    pos_q  <= pos_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.dx   = dir_q[0];
  assign rsp_o.dy   = dir_q[1];
  assign rsp_o.dz   = dir_q[2];
  assign rsp_o.px   = pos_q[0];
  assign rsp_o.py   = pos_q[1];
  assign rsp_o.pz   = pos_q[2];

endmodule
`default_nettype wire

### rtl/sphere_mesh_subdivider.sv
// Top level: control sequencer, direction store and edge table of the subdivider.
// Clear and load beats give no result; a refused beat gives one error result instead.
// A facet beat gives one vertex result for each new midpoint vertex and then 4 facet results;
// each new vertex waits on the bit-serial square root and divider in the shared normalizer.
// After reset, and after each clear beat, all 65536 entries of the edge table are swept
// before the next input beat is taken; configuration writes are taken at any time.
`default_nettype none
module sphere_mesh_subdivider #(
  parameter int unsigned SRC_VERTICES = 256,
  parameter int unsigned OUT_VERTICES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [smsub_pkg::RadW-1:0]            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [smsub_pkg::DirW-1:0]     vertex_x_i,
  input  logic signed [smsub_pkg::DirW-1:0]     vertex_y_i,
  input  logic signed [smsub_pkg::DirW-1:0]     vertex_z_i,
  input  logic [smsub_pkg::CornerW-1:0]         corner_a_i,
  input  logic [smsub_pkg::CornerW-1:0]         corner_b_i,
  input  logic [smsub_pkg::CornerW-1:0]         corner_c_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            kind_o,
  output logic [smsub_pkg::IdxW-1:0]            vertex_index_o,
  output logic signed [smsub_pkg::DirW-1:0]     dir_x_o,
  output logic signed [smsub_pkg::DirW-1:0]     dir_y_o,
  output logic signed [smsub_pkg::DirW-1:0]     dir_z_o,
  output logic signed [smsub_pkg::PosW-1:0]     pos_x_o,
  output logic signed [smsub_pkg::PosW-1:0]     pos_y_o,
  output logic signed [smsub_pkg::PosW-1:0]     pos_z_o,
  output logic [smsub_pkg::IdxW-1:0]            facet_first_o,
  output logic [smsub_pkg::IdxW-1:0]            facet_second_o,
  output logic [smsub_pkg::IdxW-1:0]            facet_third_o,
  output logic                                  last_o
);
  import smsub_pkg::*;

  localparam int unsigned AW   = $clog2(SRC_VERTICES);
  localparam int unsigned LCW  = $clog2(SRC_VERTICES + 1);
  localparam int unsigned VCW  = $clog2(OUT_VERTICES + 1);
  localparam int unsigned CmpW = (LCW > CornerW) ? LCW : CornerW;

  ctl_state_e state_q, state_d;

  logic [RadW-1:0] radius_q, radius_d;
  logic [VCW-1:0]  vc_q, vc_d;
  logic [LCW-1:0]  lc_q, lc_d;
  logic            fb_q, fb_d;
  logic [KeyW-1:0] clr_q, clr_d;
  logic [1:0]      fcnt_q, fcnt_d;
  logic [1:0]      cur_q, cur_d;
  logic [2:0]      newm_q, newm_d;
  logic [CornerW-1:0] cv_q [3];
  logic [CornerW-1:0] cv_d [3];
  logic [EntryW-1:0]  ev_q [3];
  logic [EntryW-1:0]  ev_d [3];
  logic [IdxW-1:0]    em_q [3];
  logic [IdxW-1:0]    em_d [3];
  logic [StoreW-1:0]  pd_q, pd_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      kind_q, kind_d;
  logic [IdxW-1:0] vidx_q, vidx_d;
  logic signed [DirW-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic signed [PosW-1:0] px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic [IdxW-1:0] f0_q, f1_q, f2_q, f0_d, f1_d, f2_d;
  logic            last_q, last_d;

  logic [StoreW-1:0] dmem [SRC_VERTICES];
  logic [StoreW-1:0] dir_rd_q;
  logic              dwe;
  logic [AW-1:0]     dwaddr, draddr;

  logic [EntryW-1:0] emem [EdgeDepth];
  logic [EntryW-1:0] emem_rd_q;
  logic              ewe;
  logic [KeyW-1:0]   ewaddr, eraddr;
  logic [EntryW-1:0] ewdata;

  logic            in_fire, out_free, out_load;
  logic            load_err, corner_err, cap_err;
  logic [KeyW-1:0] key [3];
  logic [KeyW-1:0] cur_key;
  logic [CornerW-1:0] p_sel, q_sel;
  logic [2:0]      new_chk;
  logic [1:0]      missing;
  logic [1:0]      first_new;

  norm_req_t nreq;
  norm_rsp_t nrsp;

  smsub_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .radius_i (radius_q),
    .req_i    (nreq),
    .rsp_o    (nrsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    key[0] = edge_key(cv_q[0], cv_q[1]);
    key[1] = edge_key(cv_q[1], cv_q[2]);
    key[2] = edge_key(cv_q[2], cv_q[0]);
    case (cur_q)
      2'd0: begin
        p_sel   = cv_q[0];
        q_sel   = cv_q[1];
        cur_key = key[0];
      end
      2'd1: begin
        p_sel   = cv_q[1];
        q_sel   = cv_q[2];
        cur_key = key[1];
      end
      default: begin
        p_sel   = cv_q[2];
        q_sel   = cv_q[0];
        cur_key = key[2];
      end
    endcase
    new_chk[0] = !ev_q[0][IdxW];
    new_chk[1] = !ev_q[1][IdxW] && (key[1] != key[0]);
    new_chk[2] = !ev_q[2][IdxW] && (key[2] != key[0]) && (key[2] != key[1]);
    missing    = 2'(new_chk[0]) + 2'(new_chk[1]) + 2'(new_chk[2]);
    cap_err    = ((VCW + 1)'(vc_q) + (VCW + 1)'(missing)) > (VCW + 1)'(OUT_VERTICES);
    if (newm_q[0]) begin
      first_new = 2'd0;
    end else if (newm_q[1]) begin
      first_new = 2'd1;
    end else begin
      first_new = 2'd2;
    end
    load_err   = fb_q || (lc_q >= LCW'(SRC_VERTICES)) || (vc_q >= VCW'(OUT_VERTICES));
    corner_err = (CmpW'(corner_a_i) >= CmpW'(lc_q)) || (CmpW'(corner_b_i) >= CmpW'(lc_q)) ||
                 (CmpW'(corner_c_i) >= CmpW'(lc_q));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == {KeyW{1'b1}}) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (mode_e'(mode_i))
            MODE_CLEAR: state_d = ST_CLEAR;
            MODE_LOAD:  state_d = load_err ? ST_ERR : ST_IDLE;
            MODE_FACET: state_d = corner_err ? ST_ERR : ST_RD0;
            default:    state_d = ST_ERR;
          endcase
        end
      end
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_CHECK;
      ST_CHECK: state_d = cap_err ? ST_ERR : ST_PICK;
      ST_PICK:  state_d = (newm_q == 3'b000) ? ST_EMITF : ST_SRCP;
      ST_SRCP:  state_d = ST_SRCQ;
      ST_SRCQ:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_NORM;
      ST_NORM:  if (nrsp.done) state_d = ST_EMITV;
      ST_EMITV: if (out_free) state_d = ST_PICK;
      ST_EMITF: if (out_free && fcnt_q == 2'd3) state_d = ST_IDLE;
      ST_ERR:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    radius_d = cfg_we_i ? cfg_wdata_i : radius_q;
    vc_d     = vc_q;
    lc_d     = lc_q;
    fb_d     = fb_q;
    clr_d    = clr_q;
    fcnt_d   = fcnt_q;
    cur_d    = cur_q;
    newm_d   = newm_q;
    cv_d     = cv_q;
    ev_d     = ev_q;
    em_d     = em_q;
    pd_d     = pd_q;
    dwe      = 1'b0;
    dwaddr   = AW'(lc_q);
    draddr   = AW'(p_sel);
    ewe      = 1'b0;
    ewaddr   = clr_q;
    ewdata   = '0;
    eraddr   = key[0];
    nreq     = '0;
    out_load = 1'b0;
    kind_d   = KIND_ERROR;
    vidx_d   = '0;
    dx_d     = '0;
    dy_d     = '0;
    dz_d     = '0;
    px_d     = '0;
    py_d     = '0;
    pz_d     = '0;
    f0_d     = '0;
    f1_d     = '0;
    f2_d     = '0;
    last_d   = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        ewe   = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              vc_d  = '0;
              lc_d  = '0;
              fb_d  = 1'b0;
              clr_d = '0;
            end
            MODE_LOAD: begin
              if (!load_err) begin
                dwe  = 1'b1;
                lc_d = lc_q + 1'b1;
                vc_d = vc_q + 1'b1;
              end
            end
            MODE_FACET: begin
              fb_d    = 1'b1;
              cv_d[0] = corner_a_i;
              cv_d[1] = corner_b_i;
              cv_d[2] = corner_c_i;
            end
            default: fb_d = fb_q;
          endcase
        end
      end
      ST_RD0: eraddr = key[0];
      ST_RD1: begin
        eraddr  = key[1];
        ev_d[0] = emem_rd_q;
      end
      ST_RD2: begin
        eraddr  = key[2];
        ev_d[1] = emem_rd_q;
      end
      ST_RD3: ev_d[2] = emem_rd_q;
      ST_CHECK: begin
        newm_d  = new_chk;
        em_d[0] = ev_q[0][IdxW-1:0];
        em_d[1] = ev_q[1][IdxW-1:0];
        em_d[2] = ev_q[2][IdxW-1:0];
      end
      ST_PICK: begin
        cur_d  = first_new;
        fcnt_d = 2'd0;
      end
      ST_SRCP: draddr = AW'(p_sel);
      ST_SRCQ: begin
        draddr = AW'(q_sel);
        pd_d   = dir_rd_q;
      end
      ST_SUM: begin
        nreq.start = 1'b1;
        nreq.sx = SumW'($signed(pd_q[47:32])) + SumW'($signed(dir_rd_q[47:32]));
        nreq.sy = SumW'($signed(pd_q[31:16])) + SumW'($signed(dir_rd_q[31:16]));
        nreq.sz = SumW'($signed(pd_q[15:0])) + SumW'($signed(dir_rd_q[15:0]));
      end
      ST_EMITV: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_VERTEX;
          vidx_d   = IdxW'(vc_q);
          dx_d     = nrsp.dx;
          dy_d     = nrsp.dy;
          dz_d     = nrsp.dz;
          px_d     = nrsp.px;
          py_d     = nrsp.py;
          pz_d     = nrsp.pz;
          last_d   = 1'b0;
          ewe      = 1'b1;
          ewaddr   = cur_key;
          ewdata   = {1'b1, IdxW'(vc_q)};
          for (int k = 0; k < 3; k++) begin
            if (key[k] == cur_key) em_d[k] = IdxW'(vc_q);
          end
          newm_d[cur_q] = 1'b0;
          vc_d = vc_q + 1'b1;
        end
      end
      ST_EMITF: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_FACET;
          last_d   = (fcnt_q == 2'd3);
          fcnt_d   = fcnt_q + 2'd1;
          case (fcnt_q)
            2'd0: begin
              f0_d = em_q[1];
              f1_d = em_q[2];
              f2_d = em_q[0];
            end
            2'd1: begin
              f0_d = IdxW'(cv_q[0]);
              f1_d = em_q[0];
              f2_d = em_q[2];
            end
            2'd2: begin
              f0_d = IdxW'(cv_q[1]);
              f1_d = em_q[1];
              f2_d = em_q[0];
            end
            default: begin
              f0_d = IdxW'(cv_q[2]);
              f1_d = em_q[2];
              f2_d = em_q[1];
            end
          endcase
        end
      end
      ST_ERR: out_load = out_free;
      default: cur_d = cur_q;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (dwe) dmem[dwaddr] <= {vertex_x_i, vertex_y_i, vertex_z_i};
    dir_rd_q <= dmem[draddr];
  end

  always_ff @(posedge clk_i) begin
    if (ewe) emem[ewaddr] <= ewdata;
    emem_rd_q <= emem[eraddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      radius_q    <= RadiusReset;
      vc_q        <= '0;
      lc_q        <= '0;
      fb_q        <= 1'b0;
      clr_q       <= '0;
      fcnt_q      <= 2'd0;
      cur_q       <= 2'd0;
      newm_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      vc_q        <= vc_d;
      lc_q        <= lc_d;
      fb_q        <= fb_d;
      clr_q       <= clr_d;
      fcnt_q      <= fcnt_d;
      cur_q       <= cur_d;
      newm_q      <= newm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cv_q <= cv_d;
    ev_q <= ev_d;
    em_q <= em_d;
    pd_q <= pd_d;
    if (out_load) begin
      kind_q <= kind_d;
      vidx_q <= vidx_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      f0_q   <= f0_d;
      f1_q   <= f1_d;
      f2_q   <= f2_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign vertex_index_o = vidx_q;
  assign dir_x_o        = dx_q;
  assign dir_y_o        = dy_q;
  assign dir_z_o        = dz_q;
  assign pos_x_o        = px_q;
  assign pos_y_o        = py_q;
  assign pos_z_o        = pz_q;
  assign facet_first_o  = f0_q;
  assign facet_second_o = f1_q;
  assign facet_third_o  = f2_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire
